[design/rau_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int MAG_BITS  = 2 * WORD_BITS + 1;
  localparam int CNT_BITS  = 7;

  localparam logic [2:0] FN_NORM = 3'd0;
  localparam logic [2:0] FN_ADD  = 3'd1;
  localparam logic [2:0] FN_SUB  = 3'd2;
  localparam logic [2:0] FN_MUL  = 3'd3;
  localparam logic [2:0] FN_DIV  = 3'd4;
  localparam logic [2:0] FN_EQ   = 3'd5;
  localparam logic [2:0] FN_LT   = 3'd6;
  localparam logic [2:0] FN_RSVD = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic [31:0] result_num;
    logic [30:0] result_den;
    logic        compare_true;
    logic [1:0]  status;
  } rau_out_t;

endpackage
`default_nettype wire

[design/rational_arithmetic_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact rational normalize/add/sub/mul/div/compare with binary GCD reduction.
// ----------------------------------------------------------------------------
// One request at a time: busy is high from acceptance through the result
// strobe, so the next request is taken in the cycle after the strobe at best.
// Cost is set by the shift-add multiplier (one bit a cycle, up to three
// products), the binary GCD loop (one shift or subtract a cycle) and the
// restoring dividers (one quotient bit a cycle).
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
// The receiver cannot stall: out_valid lasts exactly one cycle.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire rau_in_t  in_req,
  output logic          out_valid,
  output rau_out_t      out_res
);

  localparam int M = MAG_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MUL_NEXT, S_COMBINE, S_GCD_INIT, S_GCD_SHIFT, S_GCD_ODD,
    S_GCD_LOOP, S_DIV_NUM, S_DIV_DEN, S_FINISH
  } state_t;

  state_t         state_r;
  logic [2:0]     func_r;
  logic           na_neg_r, nb_neg_r;
  logic [31:0]    na_r, da_r, nb_r, db_r;
  // multiplier: product index selects operand pair
  logic [1:0]     mix_r;
  logic [63:0]    acc_r, mcand_r;
  logic [31:0]    mplier_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [63:0]    p0_r, p1_r, p2_r;   // t1, t2, denominator
  logic           top_neg_r;
  logic [M-1:0]   top_r;
  logic [63:0]    bot_r;
  logic [M-1:0]   gx_r, gy_r;
  logic [CNT_BITS-1:0] k_r;
  // divider
  logic [M-1:0]   quo_r, rem_r;
  logic [M-1:0]   qnum_r;
  logic           out_valid_r;
  rau_out_t       res_r;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  logic [M-1:0] rem_sh;
  logic [M:0]   rem_sub;
  logic [M-1:0] gcd_div;
  assign gcd_div = gx_r << k_r;
  assign rem_sh  = {rem_r[M-2:0], quo_r[M-1]};
  assign rem_sub = {1'b0, rem_sh} - {1'b0, gcd_div};

  logic [31:0] lim;
  assign lim = 32'h7FFF_FFFF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          // the strobe cycle is still busy, so no request is taken then
          if (start && !out_valid_r) begin
            func_r   <= in_req.func;
            na_neg_r <= in_req.a_num[31] ^ in_req.a_den[31];
            nb_neg_r <= in_req.b_num[31] ^ in_req.b_den[31];
            na_r     <= mag32(in_req.a_num);
            da_r     <= mag32(in_req.a_den);
            nb_r     <= mag32(in_req.b_num);
            db_r     <= (in_req.b_den == 32'd0) ? 32'd1 : mag32(in_req.b_den);
            res_r    <= '{result_num: 32'd0, result_den: 31'd0,
                          compare_true: 1'b0, status: ST_OK};
            if (in_req.func == FN_RSVD) begin
              res_r.result_den <= 31'd1;
              state_r <= S_FINISH;
            end else if (in_req.a_den == 32'd0 ||
                         (in_req.func != FN_NORM && in_req.b_den == 32'd0)) begin
              res_r.status <= ST_ZERO_DEN;
              state_r <= S_FINISH;
            end else if (in_req.func == FN_DIV && in_req.b_num == 32'd0) begin
              res_r.status <= ST_DIV_ZERO;
              state_r <= S_FINISH;
            end else begin
              mix_r   <= 2'd0;
              state_r <= S_MUL_NEXT;
            end
          end
        end
        S_MUL_NEXT: begin
          // load one product: 0 na*db (na*nb for mul, na*1 for norm), 1 nb*da, 2 denominator
          acc_r <= 64'd0;
          cnt_r <= '0;
          unique case (mix_r)
            2'd0: begin
              mcand_r <= {32'd0, na_r};
              mplier_r <= (func_r == FN_NORM) ? 32'd1 :
                          (func_r == FN_MUL) ? nb_r : db_r;
            end
            2'd1: begin
              mcand_r <= {32'd0, nb_r};
              mplier_r <= da_r;
            end
            default: begin
              mcand_r <= {32'd0, da_r};
              mplier_r <= (func_r == FN_NORM) ? 32'd1 :
                          (func_r == FN_DIV) ? nb_r : db_r;
            end
          endcase
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (mplier_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == CNT_BITS'(31)) begin
            unique case (mix_r)
              2'd0: p0_r <= mplier_r[0] ? acc_r + mcand_r : acc_r;
              2'd1: p1_r <= mplier_r[0] ? acc_r + mcand_r : acc_r;
              default: p2_r <= mplier_r[0] ? acc_r + mcand_r : acc_r;
            endcase
            if (mix_r == 2'd0 && (func_r == FN_NORM || func_r == FN_MUL ||
                                  func_r == FN_DIV))
              mix_r <= 2'd2;
            else
              mix_r <= mix_r + 2'd1;
            if (mix_r == 2'd2 || (mix_r == 2'd1 &&
                (func_r == FN_EQ || func_r == FN_LT)))
              state_r <= S_COMBINE;
            else
              state_r <= S_MUL_NEXT;
          end
        end
        S_COMBINE: begin
          bot_r <= p2_r;
          if (func_r == FN_EQ || func_r == FN_LT) begin
            // signs, zero magnitudes count as positive
            logic n1, n2;
            n1 = na_neg_r && p0_r != 64'd0;
            n2 = nb_neg_r && p1_r != 64'd0;
            if (func_r == FN_EQ)
              res_r.compare_true <= (n1 == n2) && (p0_r == p1_r);
            else if (n1 != n2)
              res_r.compare_true <= n1;
            else if (n1)
              res_r.compare_true <= p0_r > p1_r;
            else
              res_r.compare_true <= p0_r < p1_r;
            state_r <= S_FINISH;
          end else begin
            if (func_r == FN_ADD || func_r == FN_SUB) begin
              logic s2;
              s2 = nb_neg_r ^ (func_r == FN_SUB);
              if (na_neg_r == s2) begin
                top_neg_r <= na_neg_r;
                top_r <= {1'b0, p0_r} + {1'b0, p1_r};
              end else if (p0_r >= p1_r) begin
                top_neg_r <= na_neg_r;
                top_r <= {1'b0, p0_r - p1_r};
              end else begin
                top_neg_r <= s2;
                top_r <= {1'b0, p1_r - p0_r};
              end
            end else begin
              top_neg_r <= (func_r == FN_NORM) ? na_neg_r : (na_neg_r ^ nb_neg_r);
              top_r <= {1'b0, p0_r};
            end
            state_r <= S_GCD_INIT;
          end
        end
        S_GCD_INIT: begin
          if (top_r == '0) begin
            res_r.result_den <= 31'd1;
            state_r <= S_FINISH;
          end else begin
            gx_r <= top_r;
            gy_r <= {1'b0, bot_r};
            k_r  <= '0;
            state_r <= S_GCD_SHIFT;
          end
        end
        S_GCD_SHIFT: begin
          if (!gx_r[0] && !gy_r[0]) begin
            gx_r <= gx_r >> 1;
            gy_r <= gy_r >> 1;
            k_r  <= k_r + 1'b1;
          end else
            state_r <= S_GCD_ODD;
        end
        S_GCD_ODD: begin
          if (!gx_r[0]) gx_r <= gx_r >> 1;
          else state_r <= S_GCD_LOOP;
        end
        S_GCD_LOOP: begin
          if (!gy_r[0])
            gy_r <= gy_r >> 1;
          else if (gx_r > gy_r) begin
            gy_r <= gx_r - gy_r;
            gx_r <= gy_r;
          end else if (gy_r == gx_r) begin
            quo_r  <= top_r;
            rem_r  <= '0;
            cnt_r  <= '0;
            state_r <= S_DIV_NUM;
          end else
            gy_r <= gy_r - gx_r;
        end
        S_DIV_NUM, S_DIV_DEN: begin
          // restoring division, one quotient bit a cycle
          if (cnt_r == CNT_BITS'(M - 1)) begin
            cnt_r <= '0;
            rem_r <= '0;
            if (state_r == S_DIV_NUM) begin
              qnum_r <= {quo_r[M-2:0], ~rem_sub[M]};
              quo_r  <= {1'b0, bot_r};
              state_r <= S_DIV_DEN;
            end else begin
              logic [M-1:0] qd;
              qd = {quo_r[M-2:0], ~rem_sub[M]};
              if (qd > {33'd0, lim} ||
                  qnum_r > ({33'd0, lim} + {{(M-1){1'b0}}, top_neg_r})) begin
                res_r.status <= ST_OVERFLOW;
              end else begin
                res_r.result_num <= top_neg_r ? (32'd0 - qnum_r[31:0]) : qnum_r[31:0];
                res_r.result_den <= qd[30:0];
              end
              state_r <= S_FINISH;
            end
          end else begin
            if (!rem_sub[M]) begin
              rem_r <= rem_sub[M-1:0];
              quo_r <= {quo_r[M-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[M-2:0], 1'b0};
            end
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FINISH: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("busy low during strobe");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != ST_OK) |-> (out_res.result_den == 31'd0))
    else $error("error result with nonzero denominator");

endmodule
`default_nettype wire
